FILE: src/sfr_pkg.sv
package sfr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int MAX_RES     = 8;
    localparam int QUEUE_DEPTH = 16;

    localparam int W_ACT   = $clog2(PATTERN_MAX + 1);
    localparam int W_N     = $clog2(MAX_RES + 1);
    localparam int W_LIDX  = $clog2(MAX_RES);
    localparam int W_CNT   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CFG_PATTERN  = 2'd0,
        CFG_PAT_LEN  = 2'd1,
        CFG_REPL     = 2'd2,
        CFG_REPL_LEN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        out_last;
        logic [15:0] match_total;
    } t_entry;

    typedef struct packed {
        logic en;
        logic shift;
    } t_win_ctl;

endpackage

FILE: src/stream_find_replace.sv
// Streaming find-and-replace: every leftmost, non-overlapping occurrence of the
// configured pattern (up to 8 bytes) is replaced by the configured replacement
// (0 to 8 bytes); i_in_last ends a string, and the final result of each string
// carries the saturating match count (a bare result with o_out_valid low if the
// string ends with nothing left to send). Pending bytes sit in a row of window
// cells that each compare their byte against one pattern byte, so an item is
// taken every cycle in which the queue holds 8 or fewer results. Each item
// produces 0 to 8 results that go into a 16-entry output queue drained one
// result per cycle; throughput is one item per cycle while items average at
// most one result, and otherwise is set by the output port at one result per
// cycle. Configuration writes are always taken; write only while the block is
// idle. A pattern length change takes effect once the window is empty.
module stream_find_replace
    import sfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    // result items
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid,
    output logic        o_out_last,
    output logic [15:0] o_match_total
);

    logic [63:0]      r_pat;
    logic [3:0]       r_pat_len;
    logic [63:0]      r_repl;
    logic [3:0]       r_repl_len;

    logic [W_ACT-1:0] r_fill, n_fill;
    logic [W_ACT-1:0] r_act, n_act;
    logic [15:0]      r_match, n_match;
    logic [W_CNT-1:0] r_cnt, n_cnt;

    logic             acc;
    logic             pop;
    logic [W_ACT-1:0] act;
    logic [W_ACT-1:0] pat_cap;
    logic [3:0]       repl_cap;
    logic             full;
    logic             match;
    logic [15:0]      match_inc;
    logic [W_N-1:0]   n_res;
    logic [W_CNT-1:0] base;
    t_win_ctl         win_ctl;

    logic [7:0]       eff [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq;
    logic [PATTERN_MAX-1:0] care;
    logic [7:0]       eff_ext [MAX_RES];
    t_entry           list [MAX_RES];
    t_entry           q_entry [QUEUE_DEPTH];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat      <= '0;
            r_pat_len  <= '0;
            r_repl     <= '0;
            r_repl_len <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN:  r_pat      <= i_cfg_data;
                CFG_PAT_LEN:  r_pat_len  <= i_cfg_data[3:0];
                CFG_REPL:     r_repl     <= i_cfg_data;
                CFG_REPL_LEN: r_repl_len <= i_cfg_data[3:0];
            endcase
        end
    end

    assign o_in_ready  = (r_cnt <= W_CNT'(QUEUE_DEPTH - MAX_RES));
    assign acc         = i_in_valid && o_in_ready;
    assign o_res_valid = (r_cnt != '0);
    assign pop         = o_res_valid && i_res_ready;

    assign pat_cap  = (r_pat_len > 4'(PATTERN_MAX)) ? W_ACT'(PATTERN_MAX)
                                                     : W_ACT'(r_pat_len);
    assign repl_cap = (r_repl_len > 4'(MAX_RES)) ? 4'(MAX_RES) : r_repl_len;
    // length is latched only when the window starts empty
    assign act      = (r_fill == '0) ? pat_cap : r_act;
    assign full     = (act != '0) && (W_ACT'(r_fill + 1'b1) == act);
    assign match    = full && (&(eq | ~care));
    assign match_inc = (r_match != 16'hFFFF) ? r_match + 16'd1 : r_match;

    assign win_ctl.en    = acc;
    assign win_ctl.shift = full && !match;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_win
        logic [7:0] next_eff;
        if (k == PATTERN_MAX - 1) begin : g_end
            assign next_eff = 8'h00;
        end else begin : g_mid
            assign next_eff = eff[k+1];
        end
        assign care[k] = (W_ACT'(k) < act);
        sfr_win_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (win_ctl),
            .i_sel      (r_fill == W_ACT'(k)),
            .i_byte     (i_in_byte),
            .i_pat      (r_pat[8*k +: 8]),
            .i_next_eff (next_eff),
            .o_eff      (eff[k]),
            .o_eq       (eq[k])
        );
    end

    for (genvar j = 0; j < MAX_RES; j++) begin : g_ext
        if (j < PATTERN_MAX) begin : g_win_b
            assign eff_ext[j] = eff[j];
        end else begin : g_zero
            assign eff_ext[j] = 8'h00;
        end
    end

    // results caused by the current item
    always_comb begin
        logic [W_N-1:0] n_raw;
        logic [15:0]    total;
        n_raw = '0;
        if (act == '0) begin
            n_raw = W_N'(1);
        end else if (match) begin
            n_raw = W_N'(repl_cap);
        end else if (i_in_last) begin
            n_raw = W_N'(r_fill) + W_N'(1);
        end else if (full) begin
            n_raw = W_N'(1);
        end
        total = match ? match_inc : r_match;
        // string ends with nothing to send: one bare end marker
        n_res = (i_in_last && n_raw == '0) ? W_N'(1) : n_raw;
        for (int j = 0; j < MAX_RES; j++) begin
            if (n_raw == '0) begin
                list[j].out_byte  = 8'h00;
                list[j].out_valid = 1'b0;
            end else if (act == '0) begin
                list[j].out_byte  = i_in_byte;
                list[j].out_valid = 1'b1;
            end else if (match) begin
                list[j].out_byte  = r_repl[8*j +: 8];
                list[j].out_valid = 1'b1;
            end else begin
                list[j].out_byte  = eff_ext[j];
                list[j].out_valid = 1'b1;
            end
            list[j].out_last    = i_in_last && (W_N'(j) == n_res - W_N'(1));
            list[j].match_total = list[j].out_last ? total : 16'h0000;
        end
    end

    always_comb begin
        n_fill  = r_fill;
        n_act   = r_act;
        n_match = r_match;
        if (acc) begin
            n_act = act;
            if (i_in_last) begin
                n_fill  = '0;
                n_match = '0;
            end else if (match) begin
                n_fill  = '0;
                n_match = match_inc;
            end else if (act != '0 && !full) begin
                n_fill = W_ACT'(r_fill + 1'b1);
            end
        end
    end

    assign base  = r_cnt - W_CNT'(pop);
    assign n_cnt = base + (acc ? W_CNT'(n_res) : W_CNT'(0));

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_q
        logic [W_CNT-1:0] off;
        logic             wr;
        t_entry           next_e;
        assign off = W_CNT'(k) - base;
        assign wr  = acc && (W_CNT'(k) >= base) && (off < W_CNT'(n_res));
        if (k == QUEUE_DEPTH - 1) begin : g_end
            assign next_e = q_entry[k];
        end else begin : g_mid
            assign next_e = q_entry[k+1];
        end
        sfr_out_cell u_cell (
            .i_clk   (i_clk),
            .i_pop   (pop),
            .i_wr    (wr),
            .i_new   (list[off[W_LIDX-1:0]]),
            .i_next  (next_e),
            .o_entry (q_entry[k])
        );
    end

    assign o_out_byte    = q_entry[0].out_byte;
    assign o_out_valid   = q_entry[0].out_valid;
    assign o_out_last    = q_entry[0].out_last;
    assign o_match_total = q_entry[0].match_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_act   <= '0;
            r_match <= '0;
            r_cnt   <= '0;
        end else begin
            r_fill  <= n_fill;
            r_act   <= n_act;
            r_match <= n_match;
            r_cnt   <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_fill_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill == '0 || r_fill < r_act)
        else $error("window fill reached pattern length");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= W_CNT'(QUEUE_DEPTH))
        else $error("output queue overflow");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_last) |=> (r_fill == '0 && r_match == '0))
        else $error("string end did not clear window and count");

    a_accept_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_cnt != '0 || !$past(i_in_last)))
        else $error("last item produced no result");
`endif

endmodule

FILE: src/sfr_win_cell.sv
module sfr_win_cell
    import sfr_pkg::*;
(
    input  logic       i_clk,
    input  t_win_ctl   i_ctl,
    input  logic       i_sel,
    input  logic [7:0] i_byte,
    input  logic [7:0] i_pat,
    input  logic [7:0] i_next_eff,
    output logic [7:0] o_eff,
    output logic       o_eq
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // the incoming byte lands in the cell that sits at the fill position
    assign o_eff = i_sel ? i_byte : r_byte;
    assign o_eq  = (o_eff == i_pat);

    always_comb begin
        n_byte = r_byte;
        if (i_ctl.en) begin
            n_byte = i_ctl.shift ? i_next_eff : o_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

endmodule

FILE: src/sfr_out_cell.sv
module sfr_out_cell
    import sfr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_pop,
    input  logic   i_wr,
    input  t_entry i_new,
    input  t_entry i_next,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_wr) begin
            n_entry = i_new;
        end else if (i_pop) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
